// ----- rtl/core/crcdf_pkg.sv -----
// crcdf_pkg: shared types, constants and the crc-32 byte step for the frame deframer
// no dependencies
`default_nettype none

package crcdf_pkg;

  localparam int unsigned LEN_W     = 25;
  localparam int unsigned POS_W     = 4;
  localparam int unsigned CRC_W     = 32;

  localparam logic [POS_W-1:0] HDR_BYTES    = 4'd12;
  localparam logic [POS_W-1:0] POS_MAGIC    = 4'd3;
  localparam logic [POS_W-1:0] POS_CRC      = 4'd7;
  localparam logic [POS_W-1:0] POS_LENGTH   = 4'd11;
  localparam logic [POS_W-1:0] POS_CRC_FROM = 4'd8;

  localparam logic [31:0]      MIN_PAYLOAD  = 32'd6;
  localparam logic [CRC_W-1:0] CRC_POLY     = 32'hEDB8_8320;
  localparam logic [CRC_W-1:0] CRC_INIT     = 32'hFFFF_FFFF;
  localparam logic [LEN_W-1:0] MAX_LEN_RST  = 25'd65536;

  // configuration register indexes
  localparam logic REG_FRAME_MAGIC = 1'b0;
  localparam logic REG_MAX_LEN     = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_MAGIC = 2'd1,
    ST_BAD_LEN   = 2'd2,
    ST_BAD_CRC   = 2'd3
  } frame_status_t;

  // one result of the frame logic
  typedef struct packed {
    logic          has_result;
    logic          payload_valid;
    logic [7:0]    payload_byte;
    logic          last_of_frame;
    frame_status_t frame_status;
  } result_t;

  // reflected crc-32, one byte, lsb first
  function automatic logic [CRC_W-1:0] crc32_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [7:0]       b);
    logic [CRC_W-1:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/crc32_frame_deframer.sv -----
// crc32_frame_deframer: length-prefixed frame deframer with crc-32 check
// top level; uses crcdf_pkg, crcdf_in_stage, crcdf_frame and crcdf_out_stage
//
// in_*  : received byte stream, one byte per item.
// out_* : one item per payload byte (cut-through) and one per error report.
//         out_tlast marks the last payload byte of a frame, which carries
//         the crc verdict in the frame status.
// cfg_* : register writes (0 frame magic, 1 max payload length) at any edge
//         with cfg_we high, unenforced: write only while the block is idle.
// Each frame is a 12-byte header (magic, stored crc, length, little endian)
// then the payload. Header bytes give no item unless a check fails there.
// The input register loads at the input accept edge and the result register
// at the edge where that byte advances, once the result register has room.
// Throughput: 1 byte per cycle while the receiver does not stall, set by the
// single crc byte step between the two registers.
// A stalled receiver fills the result register; the input register then
// holds one more byte and in_tready drops until out_tready returns.
// After the first error item the block drops every byte until reset.
// Reset (rst_n low, synchronous) empties both registers, sets the magic to
// 0, the max length to 65536 and restarts header parsing.
`default_nettype none

module crc32_frame_deframer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] payload_byte
  output logic             out_tlast,
  output logic [2:0]       out_tuser,  // [0] payload_valid, [2:1] frame_status
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  import crcdf_pkg::*;

  logic       byte_valid;
  logic [7:0] byte_data;
  logic       space;
  logic       advance;
  result_t    result;

  assign advance = byte_valid && space;

  crcdf_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .advance    (advance),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  crcdf_frame u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .step      (advance),
    .data_byte (byte_data),
    .result    (result)
  );

  crcdf_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance && result.has_result),
    .result     (result),
    .space      (space),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

// ----- rtl/core/crcdf_in_stage.sv -----
// crcdf_in_stage: input register for the received byte stream
// depends on nothing but the clock and the downstream advance strobe
`default_nettype none

module crcdf_in_stage (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,
  input  wire logic       advance,
  output logic            byte_valid,
  output logic [7:0]      byte_data
);

  logic       valid_r, valid_nxt;
  logic [7:0] data_r;

  // free when empty or when the held byte moves on this cycle
  assign in_tready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      data_r <= in_tdata;
    end
  end

  assign byte_valid = valid_r;
  assign byte_data  = data_r;

endmodule

`default_nettype wire

// ----- rtl/core/crcdf_frame.sv -----
// crcdf_frame: header parsing, length and magic checks, crc-32 and halt state
// depends on crcdf_pkg
`default_nettype none

module crcdf_frame (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic                    cfg_index,
  input  wire logic [31:0]             cfg_wdata,
  input  wire logic                    step,
  input  wire logic [7:0]              data_byte,
  output crcdf_pkg::result_t           result
);

  import crcdf_pkg::*;

  logic [31:0]      magic_r;
  logic [LEN_W-1:0] max_len_r;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [31:0]      shift_r, shift_nxt;
  logic [CRC_W-1:0] stored_r, stored_nxt;
  logic [CRC_W-1:0] crc_r, crc_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             halted_r, halted_nxt;

  logic [31:0]      shifted;
  logic [CRC_W-1:0] crc_step;
  logic [LEN_W-1:0] len_dec;
  logic             crc_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r   <= '0;
      max_len_r <= MAX_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_MAGIC: magic_r   <= cfg_wdata;
        REG_MAX_LEN:     max_len_r <= cfg_wdata[LEN_W-1:0];
        default:         ;
      endcase
    end
  end

  assign shifted  = {data_byte, shift_r[31:8]};
  assign crc_step = crc32_byte(crc_r, data_byte);
  assign len_dec  = len_r - LEN_W'(1);
  assign crc_ok   = (~crc_step) == stored_r;

  always_comb begin
    pos_nxt    = pos_r;
    shift_nxt  = shift_r;
    stored_nxt = stored_r;
    crc_nxt    = crc_r;
    len_nxt    = len_r;
    halted_nxt = halted_r;
    result     = '{has_result: 1'b0, payload_valid: 1'b0, payload_byte: 8'd0,
                   last_of_frame: 1'b0, frame_status: ST_OK};

    if (step && !halted_r) begin
      if (pos_r != HDR_BYTES) begin
        shift_nxt = shifted;
        pos_nxt   = pos_r + POS_W'(1);
        if (pos_r >= POS_CRC_FROM) begin
          crc_nxt = crc_step;
        end
        if (pos_r == POS_MAGIC) begin
          if (shifted != magic_r) begin
            result.has_result   = 1'b1;
            result.frame_status = ST_BAD_MAGIC;
            halted_nxt          = 1'b1;
          end
        end else if (pos_r == POS_CRC) begin
          stored_nxt = shifted;
        end else if (pos_r == POS_LENGTH) begin
          if (shifted < MIN_PAYLOAD || shifted > {7'd0, max_len_r}) begin
            result.has_result   = 1'b1;
            result.frame_status = ST_BAD_LEN;
            halted_nxt          = 1'b1;
          end
          len_nxt = shifted[LEN_W-1:0];
        end
      end else begin
        result.has_result    = 1'b1;
        result.payload_valid = 1'b1;
        result.payload_byte  = data_byte;
        crc_nxt              = crc_step;
        len_nxt              = len_dec;
        if (len_dec == '0) begin
          result.last_of_frame = 1'b1;
          result.frame_status  = crc_ok ? ST_OK : ST_BAD_CRC;
          halted_nxt           = !crc_ok;
          // back to the start of the next frame
          pos_nxt    = '0;
          shift_nxt  = '0;
          stored_nxt = '0;
          crc_nxt    = CRC_INIT;
          len_nxt    = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      shift_r  <= '0;
      stored_r <= '0;
      crc_r    <= CRC_INIT;
      len_r    <= '0;
      halted_r <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      shift_r  <= shift_nxt;
      stored_r <= stored_nxt;
      crc_r    <= crc_nxt;
      len_r    <= len_nxt;
      halted_r <= halted_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/crcdf_out_stage.sv -----
// crcdf_out_stage: result register on the output stream
// depends on crcdf_pkg
`default_nettype none

module crcdf_out_stage (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               load,
  input  wire crcdf_pkg::result_t result,
  output logic                    space,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [7:0]              out_tdata,
  output logic                    out_tlast,
  output logic [2:0]              out_tuser
);

  import crcdf_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign space = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (space) begin
      valid_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && space) begin
      res_r <= result;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = res_r.payload_byte;
  assign out_tlast  = res_r.last_of_frame;
  assign out_tuser  = {res_r.frame_status, res_r.payload_valid};

endmodule

`default_nettype wire

// ----- rtl/core/crcdf_checker.sv -----
// crcdf_checker: port-level assertions for crc32_frame_deframer
// bound to the top level; uses crcdf_pkg
`default_nettype none

module crcdf_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [7:0]  out_tdata,
  input wire logic        out_tlast,
  input wire logic [2:0]  out_tuser
);

  import crcdf_pkg::*;

  logic accept_err;
  assign accept_err = out_tvalid && out_tready && (out_tuser[2:1] != ST_OK);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tlast) && $stable(out_tuser))
    else $error("output item changed while stalled");

  // an error report has no payload and no frame end, and carries a bad magic or length
  a_err_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> !out_tlast && out_tdata == 8'd0
      && (out_tuser[2:1] == ST_BAD_MAGIC || out_tuser[2:1] == ST_BAD_LEN))
    else $error("malformed error report");

  // only the final payload byte may carry a non-ok status
  a_mid_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] && !out_tlast |-> out_tuser[2:1] == ST_OK)
    else $error("status on a middle payload byte");

  // once an error item is taken the block is halted and shows nothing more
  a_halt: assert property (@(posedge clk) disable iff (!rst_n)
    accept_err |=> !out_tvalid)
    else $error("output after an error report");

  // reset empties the result register
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind crc32_frame_deframer crcdf_checker u_crcdf_checker (.*);

`default_nettype wire

// ----- test/crc32_frame_deframer_tb.sv -----
// crc32_frame_deframer_tb: self-checking bench for the crc-32 frame deframer
// streams framed bytes in, predicts payload and error items, checks every out item
// depends on crcdf_pkg and the crc32_frame_deframer rtl

typedef struct {
  bit                       payload_valid;
  bit [7:0]                 payload_byte;
  bit                       last_of_frame;
  crcdf_pkg::frame_status_t status;
} deframed_item_t;

class deframe_checker;
  bit [31:0]      magic_word;
  bit [24:0]      len_limit;
  int unsigned    hdr_count;
  bit [31:0]      hdr_word;
  bit [31:0]      crc_in_header;
  bit [31:0]      crc_reg;
  bit [24:0]      bytes_left;
  bit             halted;
  deframed_item_t due[$];
  int unsigned    mismatches;
  int unsigned    items_checked;

  function new();
    magic_word    = 32'd0;
    len_limit     = 25'd65536;
    halted        = 1'b0;
    mismatches    = 0;
    items_checked = 0;
    restart();
  endfunction

  // reflected crc-32, one byte, lsb first
  static function bit [31:0] crc_step(bit [31:0] c, bit [7:0] b);
    bit [31:0] r;
    r = c ^ {24'd0, b};
    repeat (8) r = (r >> 1) ^ (r[0] ? crcdf_pkg::CRC_POLY : 32'd0);
    return r;
  endfunction

  function void restart();
    hdr_count     = 0;
    hdr_word      = 32'd0;
    crc_in_header = 32'd0;
    crc_reg       = 32'hFFFF_FFFF;
    bytes_left    = 25'd0;
  endfunction

  function void write_reg(logic idx, bit [31:0] v);
    if (idx == crcdf_pkg::REG_FRAME_MAGIC) begin
      magic_word = v;
    end else if (idx == crcdf_pkg::REG_MAX_LEN) begin
      len_limit = v[24:0];
    end
  endfunction

  function void flag_error(crcdf_pkg::frame_status_t code);
    deframed_item_t item;
    item.payload_valid = 1'b0;
    item.payload_byte  = 8'd0;
    item.last_of_frame = 1'b0;
    item.status        = code;
    due.insert(due.size(), item);
    halted = 1'b1;
  endfunction

  // one accepted stream byte
  function void note_byte(bit [7:0] b);
    deframed_item_t item;
    if (halted) return;
    if (hdr_count < 12) begin
      hdr_word = {b, hdr_word[31:8]};
      if (hdr_count >= 8) crc_reg = crc_step(crc_reg, b);
      hdr_count++;
      if (hdr_count == 4) begin
        if (hdr_word != magic_word) flag_error(crcdf_pkg::ST_BAD_MAGIC);
      end else if (hdr_count == 8) begin
        crc_in_header = hdr_word;
      end else if (hdr_count == 12) begin
        // full 32-bit length field against the bounds
        if (hdr_word < crcdf_pkg::MIN_PAYLOAD || hdr_word > {7'd0, len_limit}) begin
          flag_error(crcdf_pkg::ST_BAD_LEN);
        end else begin
          bytes_left = hdr_word[24:0];
        end
      end
      return;
    end
    crc_reg            = crc_step(crc_reg, b);
    bytes_left         = bytes_left - 25'd1;
    item.payload_valid = 1'b1;
    item.payload_byte  = b;
    item.last_of_frame = (bytes_left == 25'd0);
    item.status        = crcdf_pkg::ST_OK;
    if (bytes_left == 25'd0) begin
      if (~crc_reg != crc_in_header) begin
        item.status = crcdf_pkg::ST_BAD_CRC;
        halted      = 1'b1;
      end
      restart();
    end
    due.insert(due.size(), item);
  endfunction

  task report(string what, int unsigned got, int unsigned want);
    mismatches++;
    $display("mismatch at out item %0d, %s: got %0h, expected %0h",
             items_checked, what, got, want);
  endtask

  task check_item(bit pv, bit [7:0] pb, bit last, bit [1:0] st);
    deframed_item_t want;
    items_checked++;
    if (due.size() == 0) begin
      report("item with none pending, payload_byte", pb, 0);
      return;
    end
    want = due.pop_front();
    if (pv != want.payload_valid) report("payload_valid", pv, want.payload_valid);
    if (pb != want.payload_byte) report("payload_byte", pb, want.payload_byte);
    if (last != want.last_of_frame) report("last_of_frame", last, want.last_of_frame);
    if (st != want.status) report("frame_status", st, want.status);
  endtask
endclass

module crc32_frame_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import crcdf_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic [2:0]  out_tuser;
  logic        cfg_we     = 1'b0;
  logic        cfg_index  = 1'b0;
  logic [31:0] cfg_wdata  = 32'd0;

  deframe_checker sb;
  int unsigned    bytes_sent = 0;
  int unsigned    burst_left = 0;
  int unsigned    ready_mode = 0;
  int unsigned    ready_mode_left = 0;
  int unsigned    tick = 0;

  crc32_frame_deframer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver: ready pattern switches between modes every so often
  always @(posedge clk) begin
    tick <= tick + 1;
    if (ready_mode_left == 0) begin
      ready_mode      <= $urandom_range(0, 3);
      ready_mode_left <= $urandom_range(32, 200);
    end else begin
      ready_mode_left <= ready_mode_left - 1;
    end
    case (ready_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      2: out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= ((tick % 11) < 7);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_byte(in_tdata);
      if (out_tvalid && out_tready) begin
        sb.check_item(out_tuser[0], out_tdata, out_tlast, out_tuser[2:1]);
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  task automatic send_byte(input bit [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 30);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  // header (magic, crc, length) then body_n payload bytes
  task automatic send_frame(input bit [31:0] magic, input bit [31:0] len_field,
                            input int unsigned body_n, input bit [31:0] crc_flip,
                            input bit extremes);
    bit [7:0]  body[$];
    bit [31:0] crc;
    bit [7:0]  b;
    crc = 32'hFFFF_FFFF;
    for (int i = 0; i < 4; i++) crc = sb.crc_step(crc, len_field[8*i +: 8]);
    for (int i = 0; i < body_n; i++) begin
      b = extremes ? ((i % 2) ? 8'hFF : 8'h00) : 8'($urandom);
      body.insert(body.size(), b);
      crc = sb.crc_step(crc, b);
    end
    crc = ~crc ^ crc_flip;
    for (int i = 0; i < 4; i++) send_byte(magic[8*i +: 8]);
    for (int i = 0; i < 4; i++) send_byte(crc[8*i +: 8]);
    for (int i = 0; i < 4; i++) send_byte(len_field[8*i +: 8]);
    foreach (body[i]) send_byte(body[i]);
  endtask

  // stop sending until every pending item is out, then let the pipeline empty
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_regs(input bit [31:0] magic, input bit [31:0] limit_word);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FRAME_MAGIC;
    cfg_wdata <= magic;
    @(posedge clk);
    cfg_index <= REG_MAX_LEN;
    cfg_wdata <= limit_word;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.write_reg(REG_FRAME_MAGIC, magic);
    sb.write_reg(REG_MAX_LEN, limit_word);
  endtask

  initial begin
    int unsigned frames_to_cfg;
    int unsigned n;
    int unsigned hi;
    bit [31:0]   magic;
    bit [31:0]   limit_word;
    bit [31:0]   len_field;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values of both registers, shortest legal frame
    send_frame(32'd0, 32'd6, 6, 32'd0, 1'b1);
    wait_drained();
    set_regs(32'hFFFF_FFFF, 32'd6);
    // length exactly at the limit
    send_frame(32'hFFFF_FFFF, 32'd6, 6, 32'd0, 1'b1);
    wait_drained();
    // limit of 2**24, junk above bit 24 is dropped
    set_regs($urandom, 32'hFF00_0000);
    send_frame(sb.magic_word, 32'd7, 7, 32'd0, 1'b0);

    frames_to_cfg = 0;
    while (bytes_sent < 440) begin
      if (frames_to_cfg == 0) begin
        wait_drained();
        case ($urandom_range(0, 3))
          0: magic = 32'd0;
          1: magic = 32'hFFFF_FFFF;
          default: magic = $urandom;
        endcase
        case ($urandom_range(0, 4))
          0: limit_word = 32'd6;
          1: limit_word = 32'h0100_0000;
          2: limit_word = $urandom_range(7, 64);
          default: limit_word = $urandom_range(65, 5000);
        endcase
        if ($urandom_range(0, 1)) limit_word = limit_word | ($urandom & 32'hFE00_0000);
        set_regs(magic, limit_word);
        frames_to_cfg = $urandom_range(2, 6);
      end
      hi = (sb.len_limit < 40) ? sb.len_limit : 40;
      case ($urandom_range(0, 9))
        0: n = (sb.len_limit < 300) ? sb.len_limit : 300;
        1: n = $urandom_range(6, (sb.len_limit < 300) ? sb.len_limit : 300);
        default: n = $urandom_range(6, hi);
      endcase
      send_frame(sb.magic_word, n, n, 32'd0, $urandom_range(0, 7) == 0);
      frames_to_cfg--;
    end

    // one error ends the run, since the block halts until reset
    wait_drained();
    case ($urandom_range(0, 4))
      0: begin
        send_frame(sb.magic_word ^ (32'd1 << $urandom_range(0, 31)), 32'd6, 6, 32'd0, 1'b0);
      end
      1: begin
        case ($urandom_range(0, 2))
          0: len_field = {7'd0, sb.len_limit} + 32'd1;
          1: len_field = 32'h8000_0000 | $urandom;
          default: len_field = 32'hFFFF_FFFF;
        endcase
        send_frame(sb.magic_word, len_field, 3, 32'd0, 1'b0);
      end
      2: begin
        send_frame(sb.magic_word, $urandom_range(0, 5), 3, 32'd0, 1'b0);
      end
      3: begin
        // limit below the minimum rejects every frame
        set_regs(sb.magic_word, $urandom_range(0, 5) | ($urandom & 32'hFE00_0000));
        n = $urandom_range(6, 20);
        send_frame(sb.magic_word, n, n, 32'd0, 1'b0);
      end
      default: begin
        n = $urandom_range(6, 30);
        send_frame(sb.magic_word, n, n, 32'd1 << $urandom_range(0, 31), 1'b0);
      end
    endcase
    // halted: these must all be dropped
    repeat (20) send_byte($urandom);
    wait_drained();
    repeat (8) @(posedge clk);

    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/crcdf_pkg.sv
rtl/core/crcdf_in_stage.sv
rtl/core/crcdf_frame.sv
rtl/core/crcdf_out_stage.sv
rtl/core/crc32_frame_deframer.sv
rtl/core/crcdf_checker.sv
test/crc32_frame_deframer_tb.sv
